[rtl/eased_viewport_tracker_assert.svh]
// assertion macros for the eased viewport tracker checker
`ifndef EASED_VIEWPORT_TRACKER_ASSERT_SVH
`define EASED_VIEWPORT_TRACKER_ASSERT_SVH
// implication checked every clock edge outside reset
`define EVT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define EVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/evt_pkg.sv]
// package: payload types, opcodes and constants of the viewport tracker
`timescale 1ns / 1ps
package evt_pkg;
    typedef enum logic [2:0] {
        OP_TICK = 3'd0, OP_FOLLOW = 3'd1, OP_LOCK = 3'd2,
        OP_SET_ZOOM = 3'd3, OP_ADD_ZOOM = 3'd4, OP_FOCUS = 3'd5
    } t_opcode;

    localparam logic [1:0] MODE_FOLLOW = 2'd0;
    localparam logic [1:0] MODE_LOCKED = 2'd1;
    localparam logic [1:0] MODE_FOCUS  = 2'd2;

    localparam logic [14:0] ZOOM_MIN    = 15'd1638;
    localparam logic [14:0] ZOOM_MAX    = 15'd16384;
    localparam logic [14:0] ZOOM_RESET  = 15'd4096;
    localparam logic [23:0] EASE_MIN    = 24'd7;
    localparam logic [15:0] RATE_RESET  = 16'd2048;
    localparam logic [24:0] ELAPSED_MAX = 25'h1FFFFFF;
    localparam logic [16:0] ONE_Q16     = 17'h10000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [19:0]        tick_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] zoom_value;
        logic [23:0]        ease_time;
        logic [23:0]        hold_time;
        logic               return_after;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic [14:0]        view_zoom;
        logic [1:0]         view_mode;
    } t_out_word;

    // clamp a wide signed zoom value into 0.4..4.0
    function automatic logic [14:0] clamp_zoom(input logic signed [17:0] z);
        logic [14:0] r;
        if (z < $signed({3'b000, ZOOM_MIN})) r = ZOOM_MIN;
        else if (z > $signed({3'b000, ZOOM_MAX})) r = ZOOM_MAX;
        else r = z[14:0];
        return r;
    endfunction
endpackage

[rtl/evt_divider.sv]
// restoring divider: quotient of (elapsed << 16) / len, one bit per cycle
`timescale 1ns / 1ps
module evt_divider import evt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [24:0] i_num,
    input  logic [23:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quot
);
    // numerator < den, so quotient fits 16 bits; shift in 16 zero bits
    logic [24:0] r_rem;
    logic [23:0] r_den;
    logic [16:0] r_quot;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [25:0] n_trial;

    assign n_trial = {r_rem, 1'b0} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
                r_cnt  <= 5'd16;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!n_trial[25]) begin
                    r_rem  <= n_trial[24:0];
                    r_quot <= {r_quot[15:0], 1'b1};
                end else begin
                    r_rem  <= {r_rem[23:0], 1'b0};
                    r_quot <= {r_quot[15:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

[rtl/eased_viewport_tracker.sv]
// top level: eased viewport tracker with a shared multiplier and a divider
//  channel | direction | handshake
//  input   | in        | i_in_valid / o_in_ready, word i_in
//  result  | out       | o_out_valid / i_out_ready, word o_out
//  config  | in        | i_cfg_we / i_cfg_wdata, no wait
// non-tick words, and ticks while locked or holding, go from decode straight to the output register
// a follow tick runs one rate multiply, then three blend passes
// an easing focus tick runs a divide when one is needed (through the
// 16-step divider), then square, cube and three blends through one 33x17 multiplier
// synchronous active-low reset restores the viewport to origin at zoom 1.0
// a result still waiting in the output register holds the next word in its last cycle
`timescale 1ns / 1ps
module eased_viewport_tracker import evt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RATE, S_DIV_WAIT, S_SQ, S_CUBE,
        S_BX, S_BY, S_BZ, S_FINISH, S_OUT
    } t_state;

    t_state r_state;
    t_in_word r_in;
    logic [15:0] r_rate;
    logic signed [31:0] r_cur_x, r_cur_y, r_from_x, r_from_y, r_to_x, r_to_y;
    logic [14:0] r_cur_zoom, r_base_zoom, r_from_zoom, r_to_zoom;
    logic [1:0]  r_mode;
    logic        r_started, r_ease_phase, r_go_back;
    logic [24:0] r_elapsed;
    logic [23:0] r_ease_len, r_hold_len;
    logic [16:0] r_f;      // blend factor Q1.16
    logic [16:0] r_s;
    logic        r_focus_tick;
    logic        r_out_valid;
    t_out_word   r_out;
    logic        r_div_start;

    // shared multiplier: signed 33 x unsigned 17
    logic signed [32:0] n_ma;
    logic [16:0]        n_mb;
    logic signed [50:0] n_prod;
    logic signed [34:0] n_fl;
    assign n_prod = n_ma * $signed({1'b0, n_mb});
    assign n_fl   = n_prod[50:16];

    logic        w_div_done;
    logic [16:0] w_quot;
    evt_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_num(r_elapsed), .i_den(r_ease_len), .o_done(w_div_done), .o_quot(w_quot)
    );

    logic [25:0] n_esum;
    logic [24:0] n_esat;
    logic signed [32:0] n_px, n_qx;
    logic [18:0] n_poly;
    assign n_esum = {6'd0, r_in.tick_time} + {1'b0, r_elapsed};
    assign n_esat = n_esum[25] ? ELAPSED_MAX : n_esum[24:0];
    assign n_poly = 19'd196608 - {1'b0, r_s, 1'b0};

    // operand selection for the shared multiplier
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        n_px = '0;
        n_qx = '0;
        case (r_state)
            S_RATE: begin
                n_ma = $signed({13'd0, r_in.tick_time});
                n_mb = {1'b0, r_rate};
            end
            S_SQ: begin
                n_ma = $signed({16'd0, r_s});
                n_mb = r_s;
            end
            S_CUBE: begin
                // 3 - 2s needs 18 bits, so it rides on the wide operand
                n_ma = $signed({14'd0, n_poly});
                n_mb = r_f;
            end
            S_BX: begin
                n_px = r_focus_tick ? 33'(r_from_x) : 33'(r_cur_x);
                n_qx = r_focus_tick ? 33'(r_to_x) : 33'(r_in.pos_x);
                n_ma = n_qx - n_px;
                n_mb = r_f;
            end
            S_BY: begin
                n_px = r_focus_tick ? 33'(r_from_y) : 33'(r_cur_y);
                n_qx = r_focus_tick ? 33'(r_to_y) : 33'(r_in.pos_y);
                n_ma = n_qx - n_px;
                n_mb = r_f;
            end
            S_BZ: begin
                n_px = r_focus_tick ? $signed({18'd0, r_from_zoom})
                                    : $signed({18'd0, r_cur_zoom});
                n_qx = r_focus_tick ? $signed({18'd0, r_to_zoom})
                                    : $signed({18'd0, r_base_zoom});
                n_ma = n_qx - n_px;
                n_mb = r_f;
            end
            default: ;
        endcase
    end

    logic [14:0] n_zoom_abs;
    logic signed [17:0] n_zsum;
    assign n_zsum = $signed({3'b000, r_base_zoom}) + 18'(r_in.zoom_value);
    assign n_zoom_abs = (r_in.opcode == OP_SET_ZOOM) ? clamp_zoom(18'(r_in.zoom_value))
                                                     : clamp_zoom(n_zsum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rate       <= RATE_RESET;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_cur_zoom   <= ZOOM_RESET;
            r_base_zoom  <= ZOOM_RESET;
            r_mode       <= MODE_FOLLOW;
            r_started    <= 1'b0;
            r_ease_phase <= 1'b0;
            r_elapsed    <= '0;
            r_from_x     <= '0;
            r_from_y     <= '0;
            r_from_zoom  <= '0;
            r_to_x       <= '0;
            r_to_y       <= '0;
            r_to_zoom    <= '0;
            r_ease_len   <= EASE_MIN;
            r_hold_len   <= '0;
            r_go_back    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_div_start  <= 1'b0;
            r_focus_tick <= 1'b0;
        end else begin
            if (i_cfg_we) r_rate <= i_cfg_wdata;
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_state <= S_OUT;
                    case (r_in.opcode)
                        OP_TICK: begin
                            if (!r_started) begin
                                r_cur_x    <= r_in.pos_x;
                                r_cur_y    <= r_in.pos_y;
                                r_cur_zoom <= r_base_zoom;
                                r_started  <= 1'b1;
                            end
                            r_focus_tick <= 1'b0;
                            if (r_mode == MODE_FOLLOW) begin
                                r_state <= S_RATE;
                            end else if (r_mode == MODE_FOCUS) begin
                                r_elapsed <= n_esat;
                                if (!r_ease_phase) begin
                                    r_focus_tick <= 1'b1;
                                    if ({1'b0, r_ease_len} <= n_esat) begin
                                        r_s     <= ONE_Q16;
                                        r_state <= S_SQ;
                                    end else begin
                                        r_div_start <= 1'b1;
                                        r_state     <= S_DIV_WAIT;
                                    end
                                end else begin
                                    r_cur_x    <= r_to_x;
                                    r_cur_y    <= r_to_y;
                                    r_cur_zoom <= r_to_zoom;
                                    if (n_esat >= {1'b0, r_hold_len})
                                        r_mode <= r_go_back ? MODE_FOLLOW : MODE_LOCKED;
                                end
                            end
                        end
                        OP_FOLLOW: r_mode <= MODE_FOLLOW;
                        OP_LOCK:   r_mode <= MODE_LOCKED;
                        OP_SET_ZOOM, OP_ADD_ZOOM: begin
                            r_base_zoom <= n_zoom_abs;
                            if (r_mode != MODE_FOCUS) r_cur_zoom <= n_zoom_abs;
                        end
                        OP_FOCUS: begin
                            r_mode       <= MODE_FOCUS;
                            r_ease_phase <= 1'b0;
                            r_elapsed    <= '0;
                            r_from_x     <= r_cur_x;
                            r_from_y     <= r_cur_y;
                            r_from_zoom  <= r_cur_zoom;
                            r_to_x       <= r_in.pos_x;
                            r_to_y       <= r_in.pos_y;
                            r_to_zoom    <= clamp_zoom(18'(r_in.zoom_value));
                            r_ease_len   <= (r_in.ease_time < EASE_MIN) ? EASE_MIN
                                                                        : r_in.ease_time;
                            r_hold_len   <= r_in.hold_time;
                            r_go_back    <= r_in.return_after;
                        end
                        default: ;
                    endcase
                end
                S_RATE: begin
                    // rate*dt/256, capped at 1.0
                    r_f     <= (n_prod[50:8] > 43'd65536) ? ONE_Q16 : n_prod[24:8];
                    r_state <= S_BX;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_s     <= w_quot;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_f     <= n_prod[32:16];
                    r_state <= S_CUBE;
                end
                S_CUBE: begin
                    r_f     <= n_prod[32:16];
                    r_state <= S_BX;
                end
                S_BX: begin
                    r_cur_x <= 32'(n_px + n_fl[32:0]);
                    r_state <= S_BY;
                end
                S_BY: begin
                    r_cur_y <= 32'(n_px + n_fl[32:0]);
                    r_state <= S_BZ;
                end
                S_BZ: begin
                    r_cur_zoom <= 15'(n_px + n_fl[32:0]);
                    r_state    <= S_FINISH;
                end
                S_FINISH: begin
                    if (r_focus_tick && r_elapsed >= {1'b0, r_ease_len}) begin
                        r_ease_phase <= 1'b1;
                        r_elapsed    <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.view_x    <= r_cur_x;
                        r_out.view_y    <= r_cur_y;
                        r_out.view_zoom <= r_cur_zoom;
                        r_out.view_mode <= r_mode;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_out_valid && i_out_ready && !(r_state == S_OUT)) r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

[rtl/evt_checker.sv]
// port-level checker for the viewport tracker, bound to the top level
`timescale 1ns / 1ps
`include "eased_viewport_tracker_assert.svh"
module evt_checker import evt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out
);
    logic w_zoom_ok;
    logic w_mode_ok;
    logic w_in_take;
    logic w_out_stall;
    assign w_zoom_ok   = (o_out.view_zoom >= ZOOM_MIN) && (o_out.view_zoom <= ZOOM_MAX);
    assign w_mode_ok   = (o_out.view_mode <= MODE_FOCUS);
    assign w_in_take   = i_in_valid && o_in_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;

    `EVT_ASSERT_IMP(a_zoom_range, i_clk, i_rst_n, o_out_valid, w_zoom_ok, "zoom out of range")
    `EVT_ASSERT_IMP(a_mode_code, i_clk, i_rst_n, o_out_valid, w_mode_ok, "bad mode")
    `EVT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_take, !o_in_ready, "ready")
    `EVT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, (o_out_valid && $stable(o_out)), "dropped")
endmodule

bind eased_viewport_tracker evt_checker u_evt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
);

[verif/eased_viewport_tracker_tb.sv]
// testbench for the eased viewport tracker: random and directed words checked against a predictor
`timescale 1ns / 1ps
module eased_viewport_tracker_tb;
    import evt_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;
    logic      cfg_we;
    logic [15:0] cfg_wdata;

    eased_viewport_tracker u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // tracker state mirror
    logic [15:0]        m_rate;
    logic signed [31:0] m_x, m_y, m_fx, m_fy, m_tx, m_ty;
    logic [14:0]        m_zoom, m_base, m_fzoom, m_tzoom;
    logic [1:0]         m_mode;
    logic               m_started, m_hold_phase, m_go_back;
    logic [24:0]        m_elapsed;
    logic [23:0]        m_ease_len, m_hold_len;

    t_in_word  word_q[$];
    t_out_word view_q[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        errors;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("[eased_viewport_tracker] ERROR");
        $finish;
    end

    function automatic longint mix(longint p, longint q, longint f);
        longint prod;
        prod = (q - p) * f;
        return p + (prod >>> 16);
    endfunction

    function automatic logic [14:0] limit_zoom(longint z);
        if (z < longint'(ZOOM_MIN)) return ZOOM_MIN;
        if (z > longint'(ZOOM_MAX)) return ZOOM_MAX;
        return z[14:0];
    endfunction

    function automatic longint ease_factor(logic [24:0] e, logic [23:0] len);
        longint s, s2;
        if (len == 0 || e >= len) s = 65536;
        else s = (longint'(e) << 16) / len;
        s2 = (s * s) >> 16;
        return (s2 * (196608 - 2 * s)) >> 16;
    endfunction

    task automatic reset_view();
        m_rate = RATE_RESET;
        m_x = 0; m_y = 0; m_fx = 0; m_fy = 0; m_tx = 0; m_ty = 0;
        m_zoom = ZOOM_RESET; m_base = ZOOM_RESET; m_fzoom = 0; m_tzoom = 0;
        m_mode = MODE_FOLLOW; m_started = 0; m_hold_phase = 0; m_elapsed = 0;
        m_ease_len = EASE_MIN; m_hold_len = 0; m_go_back = 0;
    endtask

    task automatic advance_view(input t_in_word w);
        longint f, e, a;
        t_out_word r;
        case (w.opcode)
            OP_TICK: begin
                if (!m_started) begin
                    m_x = w.pos_x; m_y = w.pos_y; m_zoom = m_base; m_started = 1;
                end
                if (m_mode == MODE_FOLLOW) begin
                    f = (longint'(m_rate) * w.tick_time) >> 8;
                    if (f > 65536) f = 65536;
                    m_x = 32'(mix(m_x, w.pos_x, f));
                    m_y = 32'(mix(m_y, w.pos_y, f));
                    m_zoom = 15'(mix(m_zoom, m_base, f));
                end else if (m_mode == MODE_FOCUS) begin
                    e = longint'(m_elapsed) + w.tick_time;
                    m_elapsed = (e > ELAPSED_MAX) ? ELAPSED_MAX : 25'(e);
                    if (!m_hold_phase) begin
                        a = ease_factor(m_elapsed, m_ease_len);
                        m_x = 32'(mix(m_fx, m_tx, a));
                        m_y = 32'(mix(m_fy, m_ty, a));
                        m_zoom = 15'(mix(m_fzoom, m_tzoom, a));
                        if (m_elapsed >= m_ease_len) begin
                            m_hold_phase = 1; m_elapsed = 0;
                        end
                    end else begin
                        m_x = m_tx; m_y = m_ty; m_zoom = m_tzoom;
                        if (m_elapsed >= m_hold_len)
                            m_mode = m_go_back ? MODE_FOLLOW : MODE_LOCKED;
                    end
                end
            end
            OP_FOLLOW: m_mode = MODE_FOLLOW;
            OP_LOCK:   m_mode = MODE_LOCKED;
            OP_SET_ZOOM, OP_ADD_ZOOM: begin
                m_base = limit_zoom(w.opcode == OP_SET_ZOOM ? longint'(w.zoom_value)
                                    : longint'(m_base) + w.zoom_value);
                if (m_mode != MODE_FOCUS) m_zoom = m_base;
            end
            OP_FOCUS: begin
                m_mode = MODE_FOCUS; m_hold_phase = 0; m_elapsed = 0;
                m_fx = m_x; m_fy = m_y; m_fzoom = m_zoom;
                m_tx = w.pos_x; m_ty = w.pos_y; m_tzoom = limit_zoom(w.zoom_value);
                m_ease_len = (w.ease_time < EASE_MIN) ? EASE_MIN : w.ease_time;
                m_hold_len = w.hold_time;
                m_go_back = w.return_after;
            end
            default: ;
        endcase
        r.view_x = m_x; r.view_y = m_y; r.view_zoom = m_zoom; r.view_mode = m_mode;
        view_q.push_back(r);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_ready) begin
            // hold the word until taken
        end else begin
            if (in_valid) advance_view(in_word);
            if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_word  <= word_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_out_word exp_w;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (view_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, out_word);
                    errors++;
                end else begin
                    exp_w = view_q.pop_front();
                    if (out_word !== exp_w) begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h m=%h actual x=%h y=%h z=%h m=%h",
                                 $time, exp_w.view_x, exp_w.view_y, exp_w.view_zoom,
                                 exp_w.view_mode, out_word.view_x, out_word.view_y,
                                 out_word.view_zoom, out_word.view_mode);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_in_word rand_word(input bit wild);
        t_in_word w;
        int pick;
        w = 152'({$urandom, $urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(99);
        if (wild) return w;
        if (pick < 55) w.opcode = OP_TICK;
        else if (pick < 62) w.opcode = OP_FOLLOW;
        else if (pick < 67) w.opcode = OP_LOCK;
        else if (pick < 73) w.opcode = OP_SET_ZOOM;
        else if (pick < 79) w.opcode = OP_ADD_ZOOM;
        else w.opcode = OP_FOCUS;
        // mostly short times so ease and hold phases finish within a few ticks
        if ($urandom_range(3) != 0) w.tick_time = 20'($urandom_range(8000));
        if ($urandom_range(3) != 0) begin
            w.ease_time = 24'($urandom_range(40000));
            w.hold_time = 24'($urandom_range(30000));
        end
        if ($urandom_range(1)) w.zoom_value = 16'($urandom_range(20000) - 2000);
        if ($urandom_range(1)) begin
            w.pos_x = $signed(32'($urandom_range(2000000))) - 1000000;
            w.pos_y = $signed(32'($urandom_range(2000000))) - 1000000;
        end
        return w;
    endfunction

    task automatic push_word(input logic [2:0] op, input logic [19:0] dt,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [15:0] zv, input logic [23:0] et,
                             input logic [23:0] ht, input logic rb);
        t_in_word w;
        w.opcode = op; w.tick_time = dt; w.pos_x = px; w.pos_y = py;
        w.zoom_value = zv; w.ease_time = et; w.hold_time = ht; w.return_after = rb;
        word_q.push_back(w);
    endtask

    task automatic drain();
        while (word_q.size() > 0 || in_valid || view_q.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_rate(input logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        m_rate = v;
    endtask

    initial begin
        rst_n = 1'b0; in_valid = 1'b0; in_word = '0; out_ready = 1'b0;
        cfg_we = 1'b0; cfg_wdata = '0; errors = 0;
        send_idle_pct = 29; recv_idle_pct = 63;
        reset_view();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // focus before the first tick, then ticks through ease and hold
        push_word(OP_FOCUS, 0, 32'h0010_0000, 32'hFFF0_0000, 16'h7FFF, 0, 24'd5, 1);
        push_word(OP_SET_ZOOM, 0, 0, 0, 16'h8000, 0, 0, 0);
        push_word(OP_TICK, 20'd3, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
        push_word(OP_TICK, 20'hFFFFF, 0, 0, 0, 0, 0, 0);
        push_word(OP_TICK, 20'hFFFFF, 0, 0, 0, 0, 0, 0);
        push_word(OP_TICK, 20'd10, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
        push_word(OP_ADD_ZOOM, 0, 0, 0, 16'h7FFF, 0, 0, 0);
        push_word(OP_ADD_ZOOM, 0, 0, 0, 16'h8000, 0, 0, 0);
        push_word(OP_SET_ZOOM, 0, 0, 0, 16'd8192, 0, 0, 0);
        push_word(OP_TICK, 20'd0, 32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0);
        push_word(OP_LOCK, 0, 0, 0, 0, 0, 0, 0);
        push_word(OP_TICK, 20'd500, 32'h0005_0000, 0, 0, 0, 0, 0);
        // long ease and hold at the largest ease and hold times
        push_word(OP_FOCUS, 0, 32'h1234_5678, 32'h8765_4321, 16'd100, 24'hFFFFFF,
                  24'hFFFFFF, 0);
        for (int k = 0; k < 40; k++) push_word(OP_TICK, 20'hFFFFF, 0, 0, 0, 0, 0, 0);
        push_word(3'd6, 20'hFFFFF, '1, '1, '1, '1, '1, 1);
        push_word(3'd7, 0, 0, 0, 0, 0, 0, 0);
        push_word(OP_FOLLOW, 0, 0, 0, 0, 0, 0, 0);
        push_word(OP_TICK, 20'd1, 32'h0100_0000, 32'hFF00_0000, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_rate(16'd0);
                1: write_rate(16'hFFFF);
                2: write_rate(16'd1);
                3: write_rate(RATE_RESET);
                default: write_rate(16'($urandom));
            endcase
            if (ph == 2) begin send_idle_pct = 63; recv_idle_pct = 29; end
            if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
            for (int k = 0; k < 270; k++)
                word_q.push_back(rand_word($urandom_range(19) == 0));
            // let everything settle once more in phase 1
            if (ph == 1) drain();
            drain();
        end

        if (errors == 0)
            $display("[eased_viewport_tracker] OK");
        else
            $display("[eased_viewport_tracker] ERROR");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/evt_pkg.sv
rtl/evt_divider.sv
rtl/eased_viewport_tracker.sv
rtl/evt_checker.sv
verif/eased_viewport_tracker_tb.sv
